/* hdl/tlik_pkg.sv */
`default_nettype none

package tlik_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN      = 24;

  // Datapath widths.
  localparam int LEN_W = 15;
  localparam int POS_W = 16;
  localparam int ANG_W = 16;
  localparam int QW    = 30;  // quotient bits of a Q2.30 ratio
  localparam int CW    = 36;  // CORDIC vector and angle width

  localparam int SQ1_N = 24;  // root bits of the radius square root
  localparam int SQ1_W = 48;
  localparam int SQ2_N = 31;  // root bits of sqrt(1 - c^2)
  localparam int SQ2_W = 62;
  localparam int DK_W  = 32;  // knee divider remainder width
  localparam int DH_W  = 41;  // hip divider remainder width

  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;

  typedef enum logic {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] z_pos;
  } ik_in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] knee_angle;
    logic signed [ANG_W-1:0] hip_angle;
    logic                    unreachable;
  } ik_out_t;

  // atan(2^-i) in Q2.30.
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:       v = 36'sd843314857;
      1:       v = 36'sd497837829;
      2:       v = 36'sd263043837;
      3:       v = 36'sd133525159;
      4:       v = 36'sd67021687;
      5:       v = 36'sd33543516;
      6:       v = 36'sd16775851;
      7:       v = 36'sd8388437;
      8:       v = 36'sd4194283;
      9:       v = 36'sd2097149;
      10:      v = 36'sd1048576;
      11:      v = 36'sd524288;
      12:      v = 36'sd262144;
      13:      v = 36'sd131072;
      14:      v = 36'sd65536;
      15:      v = 36'sd32768;
      16:      v = 36'sd16384;
      17:      v = 36'sd8192;
      18:      v = 36'sd4096;
      19:      v = 36'sd2048;
      20:      v = 36'sd1024;
      21:      v = 36'sd512;
      22:      v = 36'sd256;
      23:      v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/two_link_leg_inverse_kinematics.sv */
`default_nettype none

// Two-link leg inverse kinematics, fully pipelined. A target (x, z) is taken in every cycle
// that start_i is high; busy_o is always low. Each target produces exactly one result, shown
// on result_o for one cycle with valid_o high, in the order the targets arrived. The receiver
// has no way to stall the pipeline, so it must take every result in the cycle it appears.
// The pipeline is a chain of cells: 24 square-root cells for the radius, 30 divider cells for
// the two acos arguments, 31 square-root cells for sqrt(1 - c^2), CORDIC_STAGES CORDIC cells,
// and nine glue stages. Link lengths are written over the APB port and must only change while
// no target is in flight.
module two_link_leg_inverse_kinematics #(
  parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire tlik_pkg::ik_in_t  item_i,
  output logic                   valid_o,
  output tlik_pkg::ik_out_t      result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import tlik_pkg::*;

  localparam int LAT = 9 + SQ1_N + QW + SQ2_N + CORDIC_STAGES;

  typedef struct packed {
    logic signed [33:0]      numk;
    logic [30:0]             denk;
    logic signed [33:0]      baseh;
    logic [LEN_W-1:0]        l1;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
  } root_sb_t;

  typedef struct packed {
    logic                    neg;
    logic                    sat;
    logic                    clamp;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
  } divk_sb_t;

  typedef struct packed {
    logic neg;
    logic sat;
    logic clamp;
  } divh_sb_t;

  typedef struct packed {
    logic [30:0]             m;
    logic                    neg;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
    logic                    unr;
  } acosk_sb_t;

  typedef struct packed {
    logic [30:0] m;
    logic        neg;
  } acosh_sb_t;

  typedef struct packed {
    logic zneg;
    logic zpos;
  } atan_sb_t;

  // ---------------------------------------------------------------- configuration
  logic [LEN_W-1:0] upper_q, lower_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 15'd819;
      lower_q <= 15'd819;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_UPPER: upper_q <= pwdata[LEN_W-1:0];
        REG_LOWER: lower_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_UPPER: prdata = {{(32-LEN_W){1'b0}}, upper_q};
      REG_LOWER: prdata = {{(32-LEN_W){1'b0}}, lower_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- valid line
  logic [LAT-1:0] vld_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  // ---------------------------------------------------------------- stage A: squares
  logic signed [31:0] xx_w, zz_w;
  logic [29:0]        l1s_w, l2s_w, l1l2_w;
  logic [30:0]        a_xx_q, a_zz_q;
  logic [29:0]        a_l1s_q, a_l2s_q, a_l1l2_q;
  logic [LEN_W-1:0]   a_l1_q;
  logic signed [POS_W-1:0] a_x_q, a_z_q;

  assign xx_w   = item_i.x_pos * item_i.x_pos;
  assign zz_w   = item_i.z_pos * item_i.z_pos;
  assign l1s_w  = upper_q * upper_q;
  assign l2s_w  = lower_q * lower_q;
  assign l1l2_w = upper_q * lower_q;

  always_ff @(posedge clk_i) begin
    a_xx_q   <= xx_w[30:0];
    a_zz_q   <= zz_w[30:0];
    a_l1s_q  <= l1s_w;
    a_l2s_q  <= l2s_w;
    a_l1l2_q <= l1l2_w;
    a_l1_q   <= upper_q;
    a_x_q    <= item_i.x_pos;
    a_z_q    <= item_i.z_pos;
  end

  // ---------------------------------------------------------------- stage B: sums
  logic [31:0]        r2_w;
  logic signed [33:0] numk_w, baseh_w;
  logic [SQ1_W-1:0]   b_rem_q;
  root_sb_t           b_sb_q;

  assign r2_w    = {1'b0, a_xx_q} + {1'b0, a_zz_q};
  assign numk_w  = $signed({4'b0, a_l1s_q}) + $signed({4'b0, a_l2s_q}) - $signed({2'b0, r2_w});
  assign baseh_w = $signed({2'b0, r2_w}) + $signed({4'b0, a_l1s_q}) - $signed({4'b0, a_l2s_q});

  always_ff @(posedge clk_i) begin
    b_rem_q      <= {r2_w, 16'b0};
    b_sb_q.numk  <= numk_w;
    b_sb_q.denk  <= {a_l1l2_q, 1'b0};
    b_sb_q.baseh <= baseh_w;
    b_sb_q.l1    <= a_l1_q;
    b_sb_q.x     <= a_x_q;
    b_sb_q.z     <= a_z_q;
  end

  // ---------------------------------------------------------------- radius square root
  logic [SQ1_W-1:0] s1_rem  [SQ1_N+1];
  logic [SQ1_W-1:0] s1_root [SQ1_N+1];
  root_sb_t         s1_sb   [SQ1_N+1];

  assign s1_rem[0]  = b_rem_q;
  assign s1_root[0] = '0;
  assign s1_sb[0]   = b_sb_q;

  for (genvar k = 0; k < SQ1_N; k++) begin : g_sq1
    tlik_sqrt_cell #(
      .VW(SQ1_W), .N(SQ1_N), .K(k), .SW($bits(root_sb_t))
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (s1_rem[k]),
      .root_i (s1_root[k]),
      .side_i (s1_sb[k]),
      .rem_o  (s1_rem[k+1]),
      .root_o (s1_root[k+1]),
      .side_o (s1_sb[k+1])
    );
  end

  // ---------------------------------------------------------------- stage C: hip denominator
  logic [38:0]        denh_prod_w;
  logic [39:0]        c_denh_q;
  logic signed [41:0] c_numh_q;
  logic signed [33:0] c_numk_q;
  logic [30:0]        c_denk_q;
  logic signed [POS_W-1:0] c_x_q, c_z_q;
  root_sb_t           s1_last;

  assign s1_last     = s1_sb[SQ1_N];
  assign denh_prod_w = s1_last.l1 * s1_root[SQ1_N][23:0];

  always_ff @(posedge clk_i) begin
    c_denh_q <= {denh_prod_w, 1'b0};
    c_numh_q <= {s1_last.baseh, 8'b0};
    c_numk_q <= s1_last.numk;
    c_denk_q <= s1_last.denk;
    c_x_q    <= s1_last.x;
    c_z_q    <= s1_last.z;
  end

  // ---------------------------------------------------------------- stage D: ratio setup
  logic [33:0] negk_w;
  logic [32:0] magk_w;
  logic [41:0] negh_w;
  logic [40:0] magh_w;
  logic        clampk_w, clamph_w, eqk_w, eqh_w;

  logic [DK_W-1:0] d_remk_q, d_denk_q;
  logic [DH_W-1:0] d_remh_q, d_denh_q;
  divk_sb_t        d_sbk_q;
  divh_sb_t        d_sbh_q;

  assign negk_w   = -c_numk_q;
  assign magk_w   = c_numk_q[33] ? negk_w[32:0] : c_numk_q[32:0];
  assign clampk_w = (c_denk_q == '0) || (magk_w > {2'b0, c_denk_q});
  assign eqk_w    = magk_w == {2'b0, c_denk_q};
  assign negh_w   = -c_numh_q;
  assign magh_w   = c_numh_q[41] ? negh_w[40:0] : c_numh_q[40:0];
  assign clamph_w = (c_denh_q == '0) || (magh_w > {1'b0, c_denh_q});
  assign eqh_w    = magh_w == {1'b0, c_denh_q};

  always_ff @(posedge clk_i) begin
    d_remk_q      <= magk_w[DK_W-1:0];
    d_denk_q      <= {1'b0, c_denk_q};
    d_remh_q      <= magh_w;
    d_denh_q      <= {1'b0, c_denh_q};
    d_sbk_q.neg   <= c_numk_q[33];
    d_sbk_q.sat   <= clampk_w || eqk_w;
    d_sbk_q.clamp <= clampk_w;
    d_sbk_q.x     <= c_x_q;
    d_sbk_q.z     <= c_z_q;
    d_sbh_q.neg   <= c_numh_q[41];
    d_sbh_q.sat   <= clamph_w || eqh_w;
    d_sbh_q.clamp <= clamph_w;
  end

  // ---------------------------------------------------------------- dividers
  logic [DK_W-1:0] dk_rem [QW+1];
  logic [DK_W-1:0] dk_den [QW+1];
  logic [QW-1:0]   dk_quo [QW+1];
  divk_sb_t        dk_sb  [QW+1];
  logic [DH_W-1:0] dh_rem [QW+1];
  logic [DH_W-1:0] dh_den [QW+1];
  logic [QW-1:0]   dh_quo [QW+1];
  divh_sb_t        dh_sb  [QW+1];

  assign dk_rem[0] = d_remk_q;
  assign dk_den[0] = d_denk_q;
  assign dk_quo[0] = '0;
  assign dk_sb[0]  = d_sbk_q;
  assign dh_rem[0] = d_remh_q;
  assign dh_den[0] = d_denh_q;
  assign dh_quo[0] = '0;
  assign dh_sb[0]  = d_sbh_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    tlik_div_cell #(.DW(DK_W), .SW($bits(divk_sb_t))) u_knee (
      .clk_i  (clk_i),
      .rem_i  (dk_rem[k]),
      .den_i  (dk_den[k]),
      .quo_i  (dk_quo[k]),
      .side_i (dk_sb[k]),
      .rem_o  (dk_rem[k+1]),
      .den_o  (dk_den[k+1]),
      .quo_o  (dk_quo[k+1]),
      .side_o (dk_sb[k+1])
    );
    tlik_div_cell #(.DW(DH_W), .SW($bits(divh_sb_t))) u_hip (
      .clk_i  (clk_i),
      .rem_i  (dh_rem[k]),
      .den_i  (dh_den[k]),
      .quo_i  (dh_quo[k]),
      .side_i (dh_sb[k]),
      .rem_o  (dh_rem[k+1]),
      .den_o  (dh_den[k+1]),
      .quo_o  (dh_quo[k+1]),
      .side_o (dh_sb[k+1])
    );
  end

  // ---------------------------------------------------------------- stage E: acos arguments
  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  divk_sb_t    dk_last;
  divh_sb_t    dh_last;
  logic [30:0] mk_w, mh_w;
  logic [30:0] e_mk_q, e_mh_q;
  logic        e_negk_q, e_negh_q, e_unr_q;
  logic signed [POS_W-1:0] e_x_q, e_z_q;

  assign dk_last = dk_sb[QW];
  assign dh_last = dh_sb[QW];
  assign mk_w    = dk_last.sat ? OneQ30 : {1'b0, dk_quo[QW]};
  assign mh_w    = dh_last.sat ? OneQ30 : {1'b0, dh_quo[QW]};

  always_ff @(posedge clk_i) begin
    e_mk_q   <= mk_w;
    e_mh_q   <= mh_w;
    // A quotient of zero is not negative, whatever the numerator's sign.
    e_negk_q <= dk_last.neg && (mk_w != '0);
    e_negh_q <= dh_last.neg && (mh_w != '0);
    e_unr_q  <= dk_last.clamp || dh_last.clamp ||
                ((dk_last.x == '0) && (dk_last.z == '0));
    e_x_q    <= dk_last.x;
    e_z_q    <= dk_last.z;
  end

  // ---------------------------------------------------------------- stage F: c^2 partial products
  logic [29:0] f_pak_q, f_pah_q;
  logic [30:0] f_pabk_q, f_pabh_q;
  logic [31:0] f_pbk_q, f_pbh_q;
  logic [29:0] pak_w, pah_w;
  logic [30:0] pabk_w, pabh_w;
  logic [31:0] pbk_w, pbh_w;
  logic [30:0] f_mk_q, f_mh_q;
  logic        f_negk_q, f_negh_q, f_unr_q;
  logic signed [POS_W-1:0] f_x_q, f_z_q;

  assign pak_w  = e_mk_q[30:16] * e_mk_q[30:16];
  assign pabk_w = e_mk_q[30:16] * e_mk_q[15:0];
  assign pbk_w  = e_mk_q[15:0] * e_mk_q[15:0];
  assign pah_w  = e_mh_q[30:16] * e_mh_q[30:16];
  assign pabh_w = e_mh_q[30:16] * e_mh_q[15:0];
  assign pbh_w  = e_mh_q[15:0] * e_mh_q[15:0];

  always_ff @(posedge clk_i) begin
    f_pak_q  <= pak_w;
    f_pabk_q <= pabk_w;
    f_pbk_q  <= pbk_w;
    f_pah_q  <= pah_w;
    f_pabh_q <= pabh_w;
    f_pbh_q  <= pbh_w;
    f_mk_q   <= e_mk_q;
    f_mh_q   <= e_mh_q;
    f_negk_q <= e_negk_q;
    f_negh_q <= e_negh_q;
    f_unr_q  <= e_unr_q;
    f_x_q    <= e_x_q;
    f_z_q    <= e_z_q;
  end

  // ---------------------------------------------------------------- stage G: 1 - c^2
  localparam logic [SQ2_W-1:0] OneQ60 = {{(SQ2_W-1){1'b0}}, 1'b1} << 60;

  logic [SQ2_W-1:0] csqk_w, csqh_w;
  logic [SQ2_W-1:0] g_vk_q, g_vh_q;
  acosk_sb_t        g_sbk_q;
  acosh_sb_t        g_sbh_q;

  assign csqk_w = {f_pak_q, 32'b0} + {14'b0, f_pabk_q, 17'b0} + {30'b0, f_pbk_q};
  assign csqh_w = {f_pah_q, 32'b0} + {14'b0, f_pabh_q, 17'b0} + {30'b0, f_pbh_q};

  always_ff @(posedge clk_i) begin
    g_vk_q      <= OneQ60 - csqk_w;
    g_vh_q      <= OneQ60 - csqh_w;
    g_sbk_q.m   <= f_mk_q;
    g_sbk_q.neg <= f_negk_q;
    g_sbk_q.x   <= f_x_q;
    g_sbk_q.z   <= f_z_q;
    g_sbk_q.unr <= f_unr_q;
    g_sbh_q.m   <= f_mh_q;
    g_sbh_q.neg <= f_negh_q;
  end

  // ---------------------------------------------------------------- sin square roots
  logic [SQ2_W-1:0] sk_rem  [SQ2_N+1];
  logic [SQ2_W-1:0] sk_root [SQ2_N+1];
  acosk_sb_t        sk_sb   [SQ2_N+1];
  logic [SQ2_W-1:0] sh_rem  [SQ2_N+1];
  logic [SQ2_W-1:0] sh_root [SQ2_N+1];
  acosh_sb_t        sh_sb   [SQ2_N+1];

  assign sk_rem[0]  = g_vk_q;
  assign sk_root[0] = '0;
  assign sk_sb[0]   = g_sbk_q;
  assign sh_rem[0]  = g_vh_q;
  assign sh_root[0] = '0;
  assign sh_sb[0]   = g_sbh_q;

  for (genvar k = 0; k < SQ2_N; k++) begin : g_sq2
    tlik_sqrt_cell #(
      .VW(SQ2_W), .N(SQ2_N), .K(k), .SW($bits(acosk_sb_t))
    ) u_knee (
      .clk_i  (clk_i),
      .rem_i  (sk_rem[k]),
      .root_i (sk_root[k]),
      .side_i (sk_sb[k]),
      .rem_o  (sk_rem[k+1]),
      .root_o (sk_root[k+1]),
      .side_o (sk_sb[k+1])
    );
    tlik_sqrt_cell #(
      .VW(SQ2_W), .N(SQ2_N), .K(k), .SW($bits(acosh_sb_t))
    ) u_hip (
      .clk_i  (clk_i),
      .rem_i  (sh_rem[k]),
      .root_i (sh_root[k]),
      .side_i (sh_sb[k]),
      .rem_o  (sh_rem[k+1]),
      .root_o (sh_root[k+1]),
      .side_o (sh_sb[k+1])
    );
  end

  // ---------------------------------------------------------------- stage H: CORDIC setup
  acosk_sb_t            sk_last;
  acosh_sb_t            sh_last;
  logic signed [CW-1:0] sk_w, mk_ext_w, sh_w, mh_ext_w, xs_w, zs_w;
  logic signed [CW-1:0] h_kx_q, h_ky_q, h_ka_q;
  logic signed [CW-1:0] h_hx_q, h_hy_q, h_ha_q;
  logic signed [CW-1:0] h_tx_q, h_ty_q;
  logic                 h_unr_q, h_xzero_q;
  atan_sb_t             h_tsb_q;

  assign sk_last  = sk_sb[SQ2_N];
  assign sh_last  = sh_sb[SQ2_N];
  assign sk_w     = $signed({{(CW-31){1'b0}}, sk_root[SQ2_N][30:0]});
  assign sh_w     = $signed({{(CW-31){1'b0}}, sh_root[SQ2_N][30:0]});
  assign mk_ext_w = $signed({{(CW-31){1'b0}}, sk_last.m});
  assign mh_ext_w = $signed({{(CW-31){1'b0}}, sh_last.m});
  assign xs_w     = CW'(sk_last.x);
  assign zs_w     = CW'(sk_last.z);

  always_ff @(posedge clk_i) begin
    // A negative argument starts a quarter turn on, with the vector turned back by it.
    if (sk_last.neg) begin
      h_kx_q <= sk_w;
      h_ky_q <= mk_ext_w;
      h_ka_q <= HALF_PI_Q30;
    end else begin
      h_kx_q <= mk_ext_w;
      h_ky_q <= sk_w;
      h_ka_q <= '0;
    end
    if (sh_last.neg) begin
      h_hx_q <= sh_w;
      h_hy_q <= mh_ext_w;
      h_ha_q <= HALF_PI_Q30;
    end else begin
      h_hx_q <= mh_ext_w;
      h_hy_q <= sh_w;
      h_ha_q <= '0;
    end
    if (sk_last.x[POS_W-1]) begin
      h_tx_q <= (-xs_w) <<< 14;
      h_ty_q <= zs_w <<< 14;
    end else begin
      h_tx_q <= xs_w <<< 14;
      h_ty_q <= (-zs_w) <<< 14;
    end
    h_unr_q      <= sk_last.unr;
    h_xzero_q    <= sk_last.x == '0;
    h_tsb_q.zneg <= sk_last.z[POS_W-1];
    h_tsb_q.zpos <= !sk_last.z[POS_W-1] && (sk_last.z != '0);
  end

  // ---------------------------------------------------------------- CORDIC rows
  logic signed [CW-1:0] ck_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] ck_y [CORDIC_STAGES+1];
  logic signed [CW-1:0] ck_a [CORDIC_STAGES+1];
  logic                 ck_s [CORDIC_STAGES+1];
  logic signed [CW-1:0] ch_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] ch_y [CORDIC_STAGES+1];
  logic signed [CW-1:0] ch_a [CORDIC_STAGES+1];
  logic                 ch_s [CORDIC_STAGES+1];
  logic signed [CW-1:0] ct_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] ct_y [CORDIC_STAGES+1];
  logic signed [CW-1:0] ct_a [CORDIC_STAGES+1];
  atan_sb_t             ct_s [CORDIC_STAGES+1];

  assign ck_x[0] = h_kx_q;
  assign ck_y[0] = h_ky_q;
  assign ck_a[0] = h_ka_q;
  assign ck_s[0] = h_unr_q;
  assign ch_x[0] = h_hx_q;
  assign ch_y[0] = h_hy_q;
  assign ch_a[0] = h_ha_q;
  assign ch_s[0] = h_xzero_q;
  assign ct_x[0] = h_tx_q;
  assign ct_y[0] = h_ty_q;
  assign ct_a[0] = '0;
  assign ct_s[0] = h_tsb_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    tlik_cordic_cell #(.K(k), .SW(1)) u_knee (
      .clk_i  (clk_i),
      .xv_i   (ck_x[k]),
      .yv_i   (ck_y[k]),
      .ang_i  (ck_a[k]),
      .side_i (ck_s[k]),
      .xv_o   (ck_x[k+1]),
      .yv_o   (ck_y[k+1]),
      .ang_o  (ck_a[k+1]),
      .side_o (ck_s[k+1])
    );
    tlik_cordic_cell #(.K(k), .SW(1)) u_hip (
      .clk_i  (clk_i),
      .xv_i   (ch_x[k]),
      .yv_i   (ch_y[k]),
      .ang_i  (ch_a[k]),
      .side_i (ch_s[k]),
      .xv_o   (ch_x[k+1]),
      .yv_o   (ch_y[k+1]),
      .ang_o  (ch_a[k+1]),
      .side_o (ch_s[k+1])
    );
    tlik_cordic_cell #(.K(k), .SW($bits(atan_sb_t))) u_atan (
      .clk_i  (clk_i),
      .xv_i   (ct_x[k]),
      .yv_i   (ct_y[k]),
      .ang_i  (ct_a[k]),
      .side_i (ct_s[k]),
      .xv_o   (ct_x[k+1]),
      .yv_o   (ct_y[k+1]),
      .ang_o  (ct_a[k+1]),
      .side_o (ct_s[k+1])
    );
  end

  // ---------------------------------------------------------------- stage I: angles and rounding
  atan_sb_t             ct_last;
  logic signed [CW-1:0] tatan_w;
  logic signed [CW+1:0] knee_w, hip_w, knee_r_w, hip_r_w;
  ik_out_t              out_q;

  assign ct_last = ct_s[CORDIC_STAGES];

  always_comb begin
    if (ch_s[CORDIC_STAGES]) begin
      if (ct_last.zneg) begin
        tatan_w = HALF_PI_Q30;
      end else if (ct_last.zpos) begin
        tatan_w = -HALF_PI_Q30;
      end else begin
        tatan_w = '0;
      end
    end else begin
      tatan_w = ct_a[CORDIC_STAGES];
    end
    knee_w   = (CW+2)'(PI_Q30) - (CW+2)'(ck_a[CORDIC_STAGES]);
    hip_w    = (CW+2)'(HALF_PI_Q30) - (CW+2)'(tatan_w) - (CW+2)'(ch_a[CORDIC_STAGES]);
    // Round Q.30 to Q3.13 with halves going up.
    knee_r_w = (knee_w + (CW+2)'(65536)) >>> 17;
    hip_r_w  = (hip_w + (CW+2)'(65536)) >>> 17;
  end

  always_ff @(posedge clk_i) begin
    out_q.knee_angle  <= knee_r_w[ANG_W-1:0];
    out_q.hip_angle   <= hip_r_w[ANG_W-1:0];
    out_q.unreachable <= ck_s[CORDIC_STAGES];
  end

  assign valid_o  = vld_q[LAT-1];
  assign result_o = out_q;

endmodule

`default_nettype wire

/* hdl/tlik_sqrt_cell.sv */
`default_nettype none

// One step of the bit-pair square root: settles root bit N-1-K.
module tlik_sqrt_cell #(
  parameter int VW = 48,
  parameter int N  = 24,
  parameter int K  = 0,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic [VW-1:0] rem_i,
  input  wire logic [VW-1:0] root_i,
  input  wire logic [SW-1:0] side_i,
  output logic      [VW-1:0] rem_o,
  output logic      [VW-1:0] root_o,
  output logic      [SW-1:0] side_o
);

  localparam logic [VW-1:0] Bit = {{(VW-1){1'b0}}, 1'b1} << (2 * (N - 1 - K));

  logic [VW:0]   trial;
  logic [VW-1:0] rem_d, root_d;
  logic [VW-1:0] rem_q, root_q;
  logic [SW-1:0] side_q;

  always_comb begin
    trial = {1'b0, root_i} + {1'b0, Bit};
    if ({1'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[VW-1:0];
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

/* hdl/tlik_div_cell.sv */
`default_nettype none

// One restoring division step: produces the next quotient bit.
module tlik_div_cell #(
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  wire logic                    clk_i,
  input  wire logic [DW-1:0]           rem_i,
  input  wire logic [DW-1:0]           den_i,
  input  wire logic [tlik_pkg::QW-1:0] quo_i,
  input  wire logic [SW-1:0]           side_i,
  output logic      [DW-1:0]           rem_o,
  output logic      [DW-1:0]           den_o,
  output logic      [tlik_pkg::QW-1:0] quo_o,
  output logic      [SW-1:0]           side_o
);
  import tlik_pkg::*;

  logic [DW:0]   shifted;
  logic          take;
  logic [DW-1:0] rem_d;
  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] quo_q;
  logic [SW-1:0] side_q;

  always_comb begin
    shifted = {rem_i, 1'b0};
    take    = shifted >= {1'b0, den_i};
    if (take) begin
      rem_d = shifted[DW-1:0] - den_i;
    end else begin
      rem_d = shifted[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_i;
    quo_q  <= {quo_i[QW-2:0], take};
    side_q <= side_i;
  end

  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

/* hdl/tlik_cordic_cell.sv */
`default_nettype none

// One vectoring CORDIC rotation: turns the vector toward the x axis by atan(2^-K).
module tlik_cordic_cell #(
  parameter int K  = 0,
  parameter int SW = 1
) (
  input  wire logic                           clk_i,
  input  wire logic signed [tlik_pkg::CW-1:0] xv_i,
  input  wire logic signed [tlik_pkg::CW-1:0] yv_i,
  input  wire logic signed [tlik_pkg::CW-1:0] ang_i,
  input  wire logic        [SW-1:0]           side_i,
  output logic signed      [tlik_pkg::CW-1:0] xv_o,
  output logic signed      [tlik_pkg::CW-1:0] yv_o,
  output logic signed      [tlik_pkg::CW-1:0] ang_o,
  output logic             [SW-1:0]           side_o
);
  import tlik_pkg::*;

  localparam logic signed [CW-1:0] Step = atan_q30(K);

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] xv_d, yv_d, ang_d;
  logic signed [CW-1:0] xv_q, yv_q, ang_q;
  logic        [SW-1:0] side_q;

  always_comb begin
    dx = yv_i >>> K;
    dy = xv_i >>> K;
    if (!yv_i[CW-1]) begin
      xv_d  = xv_i + dx;
      yv_d  = yv_i - dy;
      ang_d = ang_i + Step;
    end else begin
      xv_d  = xv_i - dx;
      yv_d  = yv_i + dy;
      ang_d = ang_i - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    xv_q   <= xv_d;
    yv_q   <= yv_d;
    ang_q  <= ang_d;
    side_q <= side_i;
  end

  assign xv_o   = xv_q;
  assign yv_o   = yv_q;
  assign ang_o  = ang_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

/* sim/ik_checker.sv */
`timescale 1ns / 1ps

module ik_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_o,
  input  wire tlik_pkg::ik_in_t  item_i,
  input  wire logic              valid_o,
  input  wire tlik_pkg::ik_out_t result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic              pready,
  output int                     fail_count,
  output int                     pending
);
  import tlik_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_VAL = 64'sd3373259426;
  localparam longint HALF_PI_VAL = 64'sd1686629713;

  localparam longint ARC_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  logic [LEN_W-1:0] upper_len;
  logic [LEN_W-1:0] lower_len;
  ik_out_t          expected_angles [$];
  int               mismatches;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned acc, b;
    acc = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v -= acc + b;
        acc = (acc >> 1) + b;
      end else begin
        acc >>= 1;
      end
      b >>= 2;
    end
    return acc;
  endfunction

  // Q2.30 quotient n/d clamped to [-1, 1].
  function automatic longint clamp_ratio(longint n, longint d, inout bit clamped);
    longint mag, q, rem;
    mag = (n < 0) ? -n : n;
    if (d <= 0 || mag > d) begin
      clamped = 1'b1;
      return (n >= 0) ? ONE_Q30 : -ONE_Q30;
    end
    if (mag == d) begin
      q = ONE_Q30;
    end else begin
      rem = mag;
      q = 0;
      for (int i = 0; i < 30; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem -= d;
          q |= 1;
        end
      end
    end
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint cordic_heading(longint xv, longint yv, longint ang);
    longint dx, dy;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        ang += ARC_TAB[i];
      end else begin
        xv -= dx;
        yv += dy;
        ang -= ARC_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint arc_cos(longint c);
    longint s;
    s = longint'(floor_root(longint'(ONE_Q30 * ONE_Q30 - c * c)));
    if (c < 0) return cordic_heading(s, -c, HALF_PI_VAL);
    return cordic_heading(c, s, 0);
  endfunction

  function automatic logic signed [ANG_W-1:0] round_q13(longint v);
    longint r;
    r = (v + 65536) >>> 17;
    return r[ANG_W-1:0];
  endfunction

  function automatic ik_out_t solve_leg(ik_in_t t, logic [LEN_W-1:0] la,
                                         logic [LEN_W-1:0] lb);
    longint x, z, l1, l2, r2, l1s, l2s, ck, ch, sq, heading;
    bit clamped;
    ik_out_t o;
    x = t.x_pos;
    z = t.z_pos;
    l1 = la;
    l2 = lb;
    clamped = 1'b0;
    r2 = x * x + z * z;
    l1s = l1 * l1;
    l2s = l2 * l2;
    ck = clamp_ratio(l1s + l2s - r2, 2 * l1 * l2, clamped);
    sq = longint'(floor_root(longint'(r2 << 16)));
    ch = clamp_ratio((r2 + l1s - l2s) * 256, 2 * l1 * sq, clamped);
    if (x == 0) begin
      heading = (z < 0) ? HALF_PI_VAL : (z > 0) ? -HALF_PI_VAL : 0;
      if (z == 0) clamped = 1'b1;
    end else if (x > 0) begin
      heading = cordic_heading(x * 16384, -z * 16384, 0);
    end else begin
      heading = cordic_heading(-x * 16384, z * 16384, 0);
    end
    o.knee_angle = round_q13(PI_VAL - arc_cos(ck));
    o.hip_angle = round_q13(HALF_PI_VAL - heading - arc_cos(ch));
    o.unreachable = clamped;
    return o;
  endfunction

  assign pending = expected_angles.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ik_out_t e;
    if (!rst_ni) begin
      upper_len <= 15'd819;
      lower_len <= 15'd819;
      fail_count <= 0;
      mismatches = 0;
      expected_angles.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_e'(paddr[2]) == REG_UPPER) upper_len <= pwdata[LEN_W-1:0];
        else lower_len <= pwdata[LEN_W-1:0];
      end
      if (start_i && !busy_o) expected_angles.push_back(solve_leg(item_i, upper_len, lower_len));
      if (valid_o) begin
        if (expected_angles.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatches < 10) $display("Unexpected result transaction: %p", result_o);
          mismatches++;
        end else begin
          e = expected_angles.pop_front();
          if (e.knee_angle !== result_o.knee_angle || e.hip_angle !== result_o.hip_angle ||
              e.unreachable !== result_o.unreachable) begin
            fail_count <= fail_count + 1;
            if (mismatches < 10)
              $display("Mismatch at %0t: expected knee %0d hip %0d unr %0b, got %0d %0d %0b",
                       $realtime, e.knee_angle, e.hip_angle, e.unreachable,
                       result_o.knee_angle, result_o.hip_angle, result_o.unreachable);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tlik_pkg::*;

  localparam int DRAIN = 94 + CORDIC_STAGES_DEF + 20;
  localparam int WATCHDOG = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  ik_in_t      item_i = '0;
  logic        valid_o;
  ik_out_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          idle_pct;
  int          quiet_cycles;

  always #5 clk_i = ~clk_i;

  two_link_leg_inverse_kinematics dut (.*);

  ik_checker checker_i (.*);

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_target(input logic signed [15:0] x, input logic signed [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= '{x_pos: x, z_pos: z};
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  // Lengths only change once the pipeline has emptied.
  task automatic write_lengths(input logic [14:0] l1, input logic [14:0] l2);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    for (int r = 0; r < 2; r++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= (reg_idx_e'(r) == REG_UPPER) ? 3'd0 : 3'd4;
      pwdata <= {17'($urandom), (r == 0) ? l1 : l2};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int count, input int l1, input int l2);
    int reach, x, z;
    reach = l1 + l2 + 64;
    if (reach > 32767) reach = 32767;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 3) begin
        send_target(16'($urandom), 16'($urandom));
      end else begin
        x = $urandom_range(2 * reach) - reach;
        z = $urandom_range(2 * reach) - reach;
        if ($urandom_range(9) == 0) x = 0;
        send_target(16'(x), 16'(z));
      end
    end
  endtask

  initial begin
    int l1, l2;
    idle_pct = 20;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Origin, vertical targets, full stretch at exactly L1 + L2, field extremes.
    send_target(0, 0);
    send_target(0, -1638);
    send_target(0, 1638);
    send_target(0, -1000);
    send_target(0, 32767);
    send_target(0, -32768);
    send_target(32767, 32767);
    send_target(-32768, -32768);
    send_target(32767, -32768);
    send_target(-32768, 0);
    send_target(1, 0);
    send_target(-1, 0);
    send_target(819, -819);
    send_target(-819, -819);
    send_target(1200, -900);
    send_target(1638, 0);
    send_target(-1638, 0);
    send_target(0, 1);
    send_target(5, -3);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin l1 = 1; l2 = 32767; end
        1: begin l1 = 32767; l2 = 1; end
        2: begin l1 = 32767; l2 = 32767; end
        3: begin l1 = 1; l2 = 1; end
        default: begin l1 = $urandom_range(200, 6000); l2 = $urandom_range(200, 6000); end
      endcase
      idle_pct = (p < 2) ? 20 : (p < 4) ? 63 : 0;
      write_lengths(15'(l1), 15'(l2));
      random_phase((p < 4) ? 120 : 470, l1, l2);
      if (p == 3) idle_pct = 0;
    end
    write_lengths(15'd819, 15'd819);
    random_phase(100, 819, 819);

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
